// ===== src/triangle_tangent_space_defines.svh =====
// Assertion macros for the triangle tangent-space block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TRIANGLE_TANGENT_SPACE_DEFINES_SVH
`define TRIANGLE_TANGENT_SPACE_DEFINES_SVH

// Whenever pre holds at a clock edge, post must hold at the same edge.
`define TTS_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The condition must never be seen at a clock edge.
`define TTS_ASSERT_NEVER(label, cond, msg) \
    `TTS_ASSERT_IMPLY(label, 1'b1, !(cond), msg)

`endif

// ===== src/tts_pkg.sv =====
// Shared constants for the triangle tangent-space block.
// No dependencies; used by the front, queue and back modules.
package tts_pkg;

    localparam int CORNERS     = 3;
    localparam int AXES        = 3;
    // Vector magnitudes are scaled below 2**NORM_BITS before squaring.
    localparam int NORM_BITS   = 30;
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/tts_ifs.sv =====
// Stream interfaces of the triangle tangent-space block.
// One carries triangle corners in, the other tangent frames out.
interface tts_corner_if #(
    parameter int INDEX_BITS = 16,
    parameter int POS_BITS   = 32,
    parameter int UV_BITS    = 16
) ();
    logic                         valid;
    logic                         ready;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [POS_BITS-1:0]   pos_z;
    logic signed [UV_BITS-1:0]    tex_u;
    logic signed [UV_BITS-1:0]    tex_v;

    modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                    input ready);
    modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  output ready);
endinterface

interface tts_frame_if #(
    parameter int INDEX_BITS = 16,
    parameter int OUT_BITS   = 16
) ();
    logic                         valid;
    logic                         ready;
    logic [INDEX_BITS-1:0]        corner_index;
    logic signed [OUT_BITS-1:0]   tangent_x;
    logic signed [OUT_BITS-1:0]   tangent_y;
    logic signed [OUT_BITS-1:0]   tangent_z;
    logic signed [OUT_BITS-1:0]   bitangent_x;
    logic signed [OUT_BITS-1:0]   bitangent_y;
    logic signed [OUT_BITS-1:0]   bitangent_z;
    logic                         degenerate;
    logic                         last_of_triangle;

    modport source (output valid, corner_index, tangent_x, tangent_y, tangent_z,
                    bitangent_x, bitangent_y, bitangent_z, degenerate,
                    last_of_triangle, input ready);
    modport sink (input valid, corner_index, tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, degenerate,
                  last_of_triangle, output ready);
endinterface

// ===== src/triangle_tangent_space.sv =====
// Per-triangle tangent/bitangent unit: collector, two-entry queue, engine.
// The first two corners of a triangle are taken at one corner per cycle.
// Per triangle the engine runs the shared multiplier through the products,
// then per vector shifts all components right until the largest fits in
// NORM_BITS bits, squares, takes the root and divides, then emits 3 frames.
// Reset clears the corner count, the queue and the engine; no frames pend.
`include "triangle_tangent_space_defines.svh"

module triangle_tangent_space #(
    parameter int INDEX_BITS = 16,
    parameter int POS_BITS   = 32,
    parameter int UV_BITS    = 16,
    parameter int OUT_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tts_corner_if.sink  corner,
    tts_frame_if.source frame
);
    import tts_pkg::*;

    localparam int CW = INDEX_BITS + AXES * POS_BITS + 2 * UV_BITS;
    localparam int RW = CORNERS * CW;

    logic          push_valid;
    logic          push_ready;
    logic [RW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [RW-1:0] pop_data;

    tts_front #(
        .INDEX_BITS (INDEX_BITS),
        .POS_BITS   (POS_BITS),
        .UV_BITS    (UV_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .corner     (corner),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tts_queue #(
        .WIDTH (RW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tts_back #(
        .INDEX_BITS (INDEX_BITS),
        .POS_BITS   (POS_BITS),
        .UV_BITS    (UV_BITS),
        .OUT_BITS   (OUT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .frame     (frame)
    );

    // A degenerate frame carries only zero vectors.
    `TTS_ASSERT_IMPLY(a_degen_zero, frame.valid && frame.degenerate,
        frame.tangent_x == '0 && frame.tangent_y == '0 && frame.tangent_z == '0 &&
        frame.bitangent_x == '0 && frame.bitangent_y == '0 && frame.bitangent_z == '0,
        "degenerate frame with nonzero vector")
    // A unit vector always has at least one nonzero component.
    `TTS_ASSERT_NEVER(a_tan_nonzero,
        frame.valid && !frame.degenerate && frame.tangent_x == '0 &&
        frame.tangent_y == '0 && frame.tangent_z == '0,
        "zero tangent on a regular frame")
    `TTS_ASSERT_NEVER(a_bitan_nonzero,
        frame.valid && !frame.degenerate && frame.bitangent_x == '0 &&
        frame.bitangent_y == '0 && frame.bitangent_z == '0,
        "zero bitangent on a regular frame")

endmodule

// ===== src/tts_front.sv =====
// Corner collector: holds the first two corners of a triangle and pushes
// the whole triangle as one record. Depends on tts_pkg and tts_corner_if.
module tts_front #(
    parameter int INDEX_BITS = 16,
    parameter int POS_BITS   = 32,
    parameter int UV_BITS    = 16,
    localparam int CW = INDEX_BITS + tts_pkg::AXES * POS_BITS + 2 * UV_BITS,
    localparam int RW = tts_pkg::CORNERS * CW
) (
    input  logic          clk,
    input  logic          rst_n,
    tts_corner_if.sink    corner,
    output logic          push_valid,
    input  logic          push_ready,
    output logic [RW-1:0] push_data
);
    import tts_pkg::*;

    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic [CW-1:0] held_reg [CORNERS-1];
    logic [CW-1:0] cur;
    logic          accept;

    assign cur = {corner.tex_v, corner.tex_u, corner.pos_z, corner.pos_y,
                  corner.pos_x, corner.vertex_index};

    // The third corner passes straight through to the queue.
    assign corner.ready = !count_reg[1] || push_ready;
    assign push_valid   = corner.valid && count_reg[1];
    assign push_data    = {cur, held_reg[1], held_reg[0]};
    assign accept       = corner.valid && corner.ready;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_reg[1] ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !count_reg[1])
        begin
            held_reg[count_reg[0]] <= cur;
        end
    end

endmodule

// ===== src/tts_queue.sv =====
// Short triangle queue between the collector and the frame engine.
// Depends on tts_pkg for its depth.
module tts_queue #(
    parameter int WIDTH = 240
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import tts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != (PTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/tts_back.sv =====
// Frame engine: forms deltas, determinant and the two raw vectors with one
// shared multiplier, normalizes each vector with an iterative square root
// and divider, then emits three frames. Depends on tts_pkg and tts_frame_if.
module tts_back #(
    parameter int INDEX_BITS = 16,
    parameter int POS_BITS   = 32,
    parameter int UV_BITS    = 16,
    parameter int OUT_BITS   = 16,
    localparam int CW = INDEX_BITS + tts_pkg::AXES * POS_BITS + 2 * UV_BITS,
    localparam int RW = tts_pkg::CORNERS * CW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  logic [RW-1:0] pop_data,
    tts_frame_if.source   frame
);
    import tts_pkg::*;

    localparam int PD    = POS_BITS + 1;
    localparam int UD    = UV_BITS + 1;
    localparam int VW    = POS_BITS + UV_BITS + 3;
    localparam int MB    = NORM_BITS + 1;
    localparam int MA    = (PD > MB) ? PD : MB;
    localparam int PW    = MA + MB;
    localparam int SQW   = 2 * NORM_BITS + 2;
    localparam int RTW   = SQW + 1;
    localparam int NRW   = NORM_BITS + 1;
    localparam int QW    = OUT_BITS - 1;
    localparam int NW    = NORM_BITS + OUT_BITS - 1;
    localparam int IW    = $clog2(QW);
    localparam int OFF_U = INDEX_BITS + AXES * POS_BITS;
    localparam int OFF_V = OFF_U + UV_BITS;
    localparam int MUL_STEPS = 2 * (1 + 2 * AXES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ABS   = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DSET  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // Control.
    logic [3:0]    state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic          vsel_reg, vsel_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;
    logic          out_load;
    logic [1:0]    sidx;

    // Datapath.
    logic [INDEX_BITS-1:0]     idx_reg [CORNERS];
    logic signed [UD-1:0]      du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PD-1:0]      d1_reg [AXES];
    logic signed [PD-1:0]      d2_reg [AXES];
    logic signed [PW-1:0]      prod_reg;
    logic signed [VW-1:0]      acc_reg;
    logic                      det_neg_reg;
    logic                      det_zero_reg;
    logic signed [VW-1:0]      tvec_reg [AXES];
    logic signed [VW-1:0]      bvec_reg [AXES];
    logic [VW-1:0]             mag_reg [AXES];
    logic                      vneg_reg [AXES];
    logic [SQW-1:0]            sum_reg;
    logic [RTW-1:0]            rx_reg, rr_reg, rbit_reg;
    logic [NRW-1:0]            n_reg;
    logic                      zero_reg [2];
    logic [NW-1:0]             rem_reg, den_reg;
    logic [QW-1:0]             quo_reg;
    logic signed [OUT_BITS-1:0] res_reg [2][AXES];

    logic [INDEX_BITS-1:0]      cidx_reg;
    logic signed [OUT_BITS-1:0] tan_reg [AXES];
    logic signed [OUT_BITS-1:0] bit_reg [AXES];
    logic                       degen_reg;
    logic                       last_reg;

    // Combinational helpers.
    logic signed [POS_BITS-1:0] pin [CORNERS][AXES];
    logic signed [UV_BITS-1:0]  uin [CORNERS];
    logic signed [UV_BITS-1:0]  vin [CORNERS];
    logic signed [MA-1:0]       mul_a;
    logic signed [MB-1:0]       mul_b;
    logic signed [PW-1:0]       mul_next;
    logic [2:0]                 mj;
    logic [1:0]                 max_i;
    logic [2:0]                 jj;
    logic signed [VW-1:0]       diff_next;
    logic signed [VW-1:0]       sel_vec [AXES];
    logic [VW-1:0]              sel_mag [AXES];
    logic                       big;
    logic [SQW-1:0]             sum_next;
    logic [RTW-1:0]             rt;
    logic                       rge;
    logic [RTW-1:0]             rx_next, rr_next;
    logic                       dge;
    logic [QW-1:0]              q_final;
    logic signed [OUT_BITS-1:0] q_ext;
    logic                       degen;

    assign pop_ready = state_reg == S_IDLE;
    assign out_free  = !out_valid_reg || frame.ready;
    assign out_load  = (state_reg == S_EMIT) && out_free;
    assign sidx      = step_reg[1:0];

    always_comb
    begin
        for (int c = 0; c < CORNERS; c++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pin[c][a] = $signed(pop_data[c * CW + INDEX_BITS + a * POS_BITS +: POS_BITS]);
            end
            uin[c] = $signed(pop_data[c * CW + OFF_U +: UV_BITS]);
            vin[c] = $signed(pop_data[c * CW + OFF_V +: UV_BITS]);
        end
    end

    // Operand selection for the shared multiplier. In the product phase
    // even steps give the positive term and odd steps the negative one.
    assign mj    = step_reg[3:1];
    assign max_i = (mj >= 3'd4) ? 2'(mj - 3'd4) : 2'(mj - 3'd1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ)
        begin
            if (sidx != 2'(AXES))
            begin
                mul_a = MA'(signed'({1'b0, mag_reg[sidx][NORM_BITS-1:0]}));
                mul_b = MB'(signed'({1'b0, mag_reg[sidx][NORM_BITS-1:0]}));
            end
        end
        else
        begin
            case (mj)
                3'd0:
                begin
                    mul_a = step_reg[0] ? MA'(dv1_reg) : MA'(du1_reg);
                    mul_b = step_reg[0] ? MB'(du2_reg) : MB'(dv2_reg);
                end
                3'd1, 3'd2, 3'd3:
                begin
                    mul_a = step_reg[0] ? MA'(d2_reg[max_i]) : MA'(d1_reg[max_i]);
                    mul_b = step_reg[0] ? MB'(dv1_reg) : MB'(dv2_reg);
                end
                3'd4, 3'd5, 3'd6:
                begin
                    mul_a = step_reg[0] ? MA'(d1_reg[max_i]) : MA'(d2_reg[max_i]);
                    mul_b = step_reg[0] ? MB'(du2_reg) : MB'(du1_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_next  = PW'(mul_a) * PW'(mul_b);
    assign jj        = step_reg[3:1] - 3'd1;
    assign diff_next = acc_reg - VW'(prod_reg);

    always_comb
    begin
        big = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            sel_vec[a] = vsel_reg ? bvec_reg[a] : tvec_reg[a];
            sel_mag[a] = sel_vec[a][VW-1] ? VW'(-sel_vec[a]) : VW'(sel_vec[a]);
            big = big | (|mag_reg[a][VW-1:NORM_BITS]);
        end
    end

    assign sum_next = sum_reg + SQW'(prod_reg);

    // One step of the digit-by-digit integer square root.
    assign rt      = rr_reg + rbit_reg;
    assign rge     = rx_reg >= rt;
    assign rx_next = rge ? rx_reg - rt : rx_reg;
    assign rr_next = rge ? (rr_reg >> 1) + rbit_reg : rr_reg >> 1;

    // One step of the restoring divider.
    assign dge     = rem_reg >= den_reg;
    assign q_final = {quo_reg[QW-2:0], dge};
    assign q_ext   = signed'(OUT_BITS'(q_final));

    assign degen = det_zero_reg || zero_reg[0] || zero_reg[1];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        vsel_next      = vsel_reg;
        iter_next      = iter_reg;
        out_valid_next = out_load || (out_valid_reg && !frame.ready);
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = S_MUL;
                    step_next  = 4'd0;
                end
            end
            S_MUL:
            begin
                if (step_reg == 4'(MUL_STEPS))
                begin
                    state_next = S_ABS;
                    vsel_next  = 1'b0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_ABS:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!big)
                begin
                    state_next = S_SQ;
                    step_next  = 4'd0;
                end
            end
            S_SQ:
            begin
                if (step_reg == 4'(AXES))
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_SQRT:
            begin
                if (rbit_reg[0])
                begin
                    state_next = S_DSET;
                    step_next  = 4'd0;
                end
            end
            S_DSET:
            begin
                state_next = S_DIV;
                iter_next  = IW'(QW - 1);
            end
            S_DIV:
            begin
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    if (step_reg == 4'(AXES - 1))
                    begin
                        step_next = 4'd0;
                        if (!vsel_reg)
                        begin
                            vsel_next  = 1'b1;
                            state_next = S_ABS;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_DSET;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (step_reg == 4'(CORNERS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 4'd0;
            vsel_reg      <= 1'b0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            vsel_reg      <= vsel_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    for (int c = 0; c < CORNERS; c++)
                    begin
                        idx_reg[c] <= pop_data[c * CW +: INDEX_BITS];
                    end
                    for (int a = 0; a < AXES; a++)
                    begin
                        d1_reg[a] <= PD'(pin[1][a]) - PD'(pin[0][a]);
                        d2_reg[a] <= PD'(pin[2][a]) - PD'(pin[0][a]);
                    end
                    du1_reg <= UD'(uin[1]) - UD'(uin[0]);
                    dv1_reg <= UD'(vin[1]) - UD'(vin[0]);
                    du2_reg <= UD'(uin[2]) - UD'(uin[0]);
                    dv2_reg <= UD'(vin[2]) - UD'(vin[0]);
                end
            end
            S_MUL:
            begin
                prod_reg <= mul_next;
                if (step_reg != 4'd0)
                begin
                    if (step_reg[0])
                    begin
                        acc_reg <= VW'(prod_reg);
                    end
                    else if (jj == 3'd0)
                    begin
                        det_neg_reg  <= diff_next[VW-1];
                        det_zero_reg <= diff_next == '0;
                    end
                    else if (jj <= 3'd3)
                    begin
                        tvec_reg[2'(jj - 3'd1)] <= diff_next;
                    end
                    else
                    begin
                        bvec_reg[2'(jj - 3'd4)] <= diff_next;
                    end
                end
            end
            S_ABS:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    mag_reg[a]  <= sel_mag[a];
                    vneg_reg[a] <= sel_vec[a][VW-1];
                end
            end
            S_SHIFT:
            begin
                if (big)
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        mag_reg[a] <= mag_reg[a] >> 1;
                    end
                end
            end
            S_SQ:
            begin
                prod_reg <= mul_next;
                if (step_reg == 4'd0)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                end
                if (step_reg == 4'(AXES))
                begin
                    rx_reg   <= RTW'(sum_next);
                    rr_reg   <= '0;
                    rbit_reg <= RTW'(1) << (RTW - 1);
                end
            end
            S_SQRT:
            begin
                rx_reg   <= rx_next;
                rr_reg   <= rr_next;
                rbit_reg <= rbit_reg >> 2;
                if (rbit_reg[0])
                begin
                    n_reg <= rr_next[NRW-1:0];
                end
            end
            S_DSET:
            begin
                rem_reg <= (NW'(mag_reg[sidx][NORM_BITS-1:0]) << (OUT_BITS - 2))
                           + NW'(n_reg >> 1);
                den_reg <= NW'(n_reg) << (QW - 1);
                quo_reg <= '0;
                zero_reg[vsel_reg] <= n_reg == '0;
            end
            S_DIV:
            begin
                rem_reg <= dge ? rem_reg - den_reg : rem_reg;
                den_reg <= den_reg >> 1;
                quo_reg <= q_final;
                if (iter_reg == '0)
                begin
                    res_reg[vsel_reg][sidx] <= (vneg_reg[sidx] ^ det_neg_reg) ? -q_ext : q_ext;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cidx_reg  <= idx_reg[sidx];
                    degen_reg <= degen;
                    last_reg  <= step_reg == 4'(CORNERS - 1);
                    for (int a = 0; a < AXES; a++)
                    begin
                        tan_reg[a] <= degen ? '0 : res_reg[0][a];
                        bit_reg[a] <= degen ? '0 : res_reg[1][a];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign frame.valid            = out_valid_reg;
    assign frame.corner_index     = cidx_reg;
    assign frame.tangent_x        = tan_reg[0];
    assign frame.tangent_y        = tan_reg[1];
    assign frame.tangent_z        = tan_reg[2];
    assign frame.bitangent_x      = bit_reg[0];
    assign frame.bitangent_y      = bit_reg[1];
    assign frame.bitangent_z      = bit_reg[2];
    assign frame.degenerate       = degen_reg;
    assign frame.last_of_triangle = last_reg;

endmodule
